@@ rtl/pnf_pkg.sv @@
`default_nettype none
package pnf_pkg;
  localparam int FRAC_BITS = 16;
  localparam int TABLE_BITS = 8;
  localparam int OCT_BITS = 3;
  localparam logic [3:0] MAX_OCTAVES = 4'd8;
  localparam logic [3:0] OCT_RESET = 4'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_P0, S_P1, S_A0, S_A1, S_B0, S_B1, S_G0, S_G1, S_G2, S_G3,
    S_L0, S_L1, S_L2, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    RD_CX, RD_CX1, RD_A, RD_A1, RD_B, RD_B1, RD_AA, RD_AB, RD_BA, RD_BB
  } rd_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    start_eval;
    logic    start_octave;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    lerp0;
    logic    lerp1;
    logic    finish;
  } ctrl_t;

  typedef struct packed {
    logic last_octave;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/perlin_noise_2d_fbm_unit.sv @@
`default_nettype none
// 2D gradient noise, summed over octaves.
// Request: start with command. command 0 writes perm entry entry_index with
// entry_value, no result. command 1 evaluates at (x_coord,
// y_coord), signed Q8.16; busy stays high until the result.
// Result: noise_value (signed Q3.16, saturated) with done high for one cycle.
// Each octave is paced by the single read port of the permutation
// memory, which serves its ten dependent reads one after another.
// octave_count (reset value 4) is written by cfg_we/cfg_data; the user
// must write it only while idle, which the block does not enforce.
// Reset clears the controller and the register; table contents are kept
// and must be loaded before use. The receiver cannot stall: each result is
// shown for exactly one cycle.
module perlin_noise_2d_fbm_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command,
  input  wire logic [7:0]         entry_index,
  input  wire logic [7:0]         entry_value,
  input  wire logic signed [23:0] x_coord,
  input  wire logic signed [23:0] y_coord,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_data,
  output logic                    done,
  output logic signed [18:0]      noise_value
);
  pnf_pkg::ctrl_t ctrl;
  pnf_pkg::stat_t stat;
  logic [3:0] octave_count;

  always_ff @(posedge clk) begin
    if (rst) octave_count <= pnf_pkg::OCT_RESET;
    else if (cfg_we) octave_count <= cfg_data;
  end

  pnf_ctrl u_ctrl (.clk, .rst, .start, .command, .busy, .stat, .ctrl);
  pnf_datapath u_dp (.clk, .rst, .ctrl, .stat, .octave_count, .entry_index,
    .entry_value, .x_coord, .y_coord, .done, .noise_value);

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !command) |=> !busy) else $error("load made busy");
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command) |=> busy) else $error("eval not started");
`endif
endmodule
`default_nettype wire

@@ rtl/pnf_ctrl.sv @@
`default_nettype none
module pnf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          command,
  output logic               busy,
  input  wire pnf_pkg::stat_t stat,
  output pnf_pkg::ctrl_t     ctrl
);
  pnf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pnf_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pnf_pkg::S_IDLE: if (start && command) state_next = pnf_pkg::S_P0;
      pnf_pkg::S_P0: state_next = pnf_pkg::S_P1;
      pnf_pkg::S_P1: state_next = pnf_pkg::S_A0;
      pnf_pkg::S_A0: state_next = pnf_pkg::S_A1;
      pnf_pkg::S_A1: state_next = pnf_pkg::S_B0;
      pnf_pkg::S_B0: state_next = pnf_pkg::S_B1;
      pnf_pkg::S_B1: state_next = pnf_pkg::S_G0;
      pnf_pkg::S_G0: state_next = pnf_pkg::S_G1;
      pnf_pkg::S_G1: state_next = pnf_pkg::S_G2;
      pnf_pkg::S_G2: state_next = pnf_pkg::S_G3;
      pnf_pkg::S_G3: state_next = pnf_pkg::S_L0;
      pnf_pkg::S_L0: state_next = pnf_pkg::S_L1;
      pnf_pkg::S_L1: state_next = pnf_pkg::S_L2;
      pnf_pkg::S_L2: state_next = stat.last_octave ? pnf_pkg::S_DONE : pnf_pkg::S_P0;
      pnf_pkg::S_DONE: state_next = pnf_pkg::S_IDLE;
      default: state_next = pnf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.rd_sel = pnf_pkg::RD_CX;
    busy = (state != pnf_pkg::S_IDLE);
    unique case (state)
      pnf_pkg::S_IDLE: begin
        ctrl.load_item = start && !command;
        ctrl.start_eval = start && command;
      end
      pnf_pkg::S_P0: begin ctrl.start_octave = 1'b1; end
      pnf_pkg::S_P1: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_CX; end
      pnf_pkg::S_A0: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_CX1; end
      pnf_pkg::S_A1: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_A; end
      pnf_pkg::S_B0: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_A1; end
      pnf_pkg::S_B1: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_B; end
      pnf_pkg::S_G0: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_B1; end
      pnf_pkg::S_G1: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_AA; end
      pnf_pkg::S_G2: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_AB; end
      pnf_pkg::S_G3: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_BA; end
      pnf_pkg::S_L0: begin ctrl.rd_en = 1'b1; ctrl.rd_sel = pnf_pkg::RD_BB; end
      pnf_pkg::S_L1: begin ctrl.lerp0 = 1'b1; end
      pnf_pkg::S_L2: begin ctrl.lerp1 = 1'b1; end
      pnf_pkg::S_DONE: begin ctrl.finish = 1'b1; end
      default: begin end
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/pnf_datapath.sv @@
`default_nettype none
module pnf_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pnf_pkg::ctrl_t     ctrl,
  output pnf_pkg::stat_t          stat,
  input  wire logic [3:0]         octave_count,
  input  wire logic [7:0]         entry_index,
  input  wire logic [7:0]         entry_value,
  input  wire logic signed [23:0] x_coord,
  input  wire logic signed [23:0] y_coord,
  output logic                    done,
  output logic signed [18:0]      noise_value
);
  localparam int F = pnf_pkg::FRAC_BITS;
  localparam int TB = pnf_pkg::TABLE_BITS;

  logic [TB-1:0] perm [2**TB];
  logic [TB-1:0] rd_addr, rd_data;
  logic [TB-1:0] tag;

  logic [23:0] xs, ys;
  logic [pnf_pkg::OCT_BITS-1:0] oct, oct_last;
  logic [TB-1:0] cx, cy;
  logic [F-1:0] fx, fy;
  logic [TB-1:0] pa, pb, a, b;
  logic [2:0] h_aa, h_ab, h_ba;
  logic [F:0] u, v;
  logic signed [F+2:0] r0, r1;
  logic signed [F+6:0] acc;

  // Fade unit: registered stages, shared between x and y over cycles
  logic [F-1:0] fd_in;
  logic [2*F+3:0] poly;
  logic [F+3:0] p1;
  logic [F-1:0] t2, t3;
  logic [2*F+3:0] fprod;
  logic [F+3:0] p1_r;
  logic [F-1:0] t2_r, t3_r, fin_r;
  logic [3:0] fd_step;

  always_ff @(posedge clk) begin
    if (ctrl.load_item) perm[entry_index] <= entry_value;
    if (ctrl.rd_en) rd_data <= perm[rd_addr];
  end

  always_comb begin
    case (ctrl.rd_sel)
      pnf_pkg::RD_CX:  rd_addr = cx;
      pnf_pkg::RD_CX1: rd_addr = cx + 1'b1;
      pnf_pkg::RD_A:   rd_addr = pa + cy;
      pnf_pkg::RD_A1:  rd_addr = pa + cy + 1'b1;
      pnf_pkg::RD_B:   rd_addr = pb + cy;
      pnf_pkg::RD_B1:  rd_addr = pb + cy + 1'b1;
      default:         rd_addr = tag;
    endcase
  end

  // one fade stage per cycle: poly and t2 -> t3 -> product -> u or v
  always_comb begin
    poly = (36'(10) << (2*F)) - ((36'(15) * 36'(fd_in)) << F)
           + 36'(6) * 36'(fd_in) * 36'(fd_in);
    p1 = poly[2*F+3:F];
    t2 = 16'((32'(fd_in) * 32'(fd_in)) >> F);
    t3 = 16'((32'(t2_r) * 32'(fd_in)) >> F);
    fprod = 36'(p1_r) * 36'(t3_r);
  end

  logic sel_y;
  assign sel_y = fd_step[3];
  assign fd_in = sel_y ? fy : fx;

  // dot products with gradient
  function automatic logic signed [F+2:0] dotg(input logic [2:0] g,
      input logic signed [F+2:0] dx, input logic signed [F+2:0] dy);
    logic signed [F+2:0] r;
    begin
      case (g)
        3'd0: r = dx + dy;
        3'd1: r = -dx + dy;
        3'd2: r = dx - dy;
        3'd3: r = -dx - dy;
        3'd4: r = dx;
        3'd5: r = -dx;
        3'd6: r = dy;
        default: r = -dy;
      endcase
      dotg = r;
    end
  endfunction

  function automatic logic signed [F+2:0] lerp(input logic signed [F+2:0] la,
      input logic signed [F+2:0] lb, input logic [F:0] t);
    logic signed [F+3:0] d;
    logic signed [2*F+5:0] p;
    begin
      d = (F+4)'(lb) - (F+4)'(la);
      p = $signed({1'b0, t}) * d;
      lerp = (F+3)'(la + (F+3)'(p >>> F));
    end
  endfunction

  logic signed [F+2:0] x0, y0, x1, y1;
  assign x0 = $signed({3'b000, fx});
  assign y0 = $signed({3'b000, fy});
  assign x1 = x0 - $signed((F+3)'(1) << F);
  assign y1 = y0 - $signed((F+3)'(1) << F);

  logic signed [F+2:0] g_aa, g_ab, g_ba, g_bb, r_new;
  always_comb begin
    g_aa = dotg(h_aa, x0, y0);
    g_ba = dotg(h_ba, x1, y0);
    g_ab = dotg(h_ab, x0, y1);
    g_bb = dotg(rd_data[2:0], x1, y1);
    r_new = lerp(r0, r1, v);
  end

  logic signed [F+6:0] sum_next;
  assign sum_next = acc + ((F+7)'(r_new) >>> oct);
  assign stat.last_octave = (oct == oct_last);

  logic [3:0] oc_clamp;
  assign oc_clamp = (octave_count == 4'd0) ? 4'd1 :
                    (octave_count > pnf_pkg::MAX_OCTAVES) ? pnf_pkg::MAX_OCTAVES : octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      fd_step <= '0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.start_eval) begin
        xs <= x_coord;
        ys <= y_coord;
        oct <= '0;
        oct_last <= pnf_pkg::OCT_BITS'(oc_clamp - 4'd1);
        acc <= '0;
      end
      if (ctrl.start_octave) begin
        cx <= xs[F+TB-1:F];
        cy <= ys[F+TB-1:F];
        fx <= xs[F-1:0];
        fy <= ys[F-1:0];
        fd_step <= 4'd1;
      end else if (fd_step == 4'd4) begin
        fd_step <= 4'd9;
      end else if (fd_step == 4'd12) begin
        fd_step <= 4'd0;
      end else if (fd_step != 4'd0) begin
        fd_step <= fd_step + 4'd1;
      end
      // fade pipeline: x on steps 1..4, y on steps 9..12
      case (fd_step[2:0])
        3'd1: begin p1_r <= p1; t2_r <= t2; end
        3'd2: t3_r <= t3;
        3'd3: fin_r <= 16'(fprod >> F);
        3'd4: if (sel_y) v <= {1'b0, fin_r}; else u <= {1'b0, fin_r};
        default: begin end
      endcase
      case (ctrl.rd_sel)
        pnf_pkg::RD_CX1: if (ctrl.rd_en) pa <= rd_data;
        default: begin end
      endcase
      if (ctrl.rd_en) begin
        case (ctrl.rd_sel)
          pnf_pkg::RD_A:   pb <= rd_data;
          pnf_pkg::RD_A1:  a <= rd_data;
          pnf_pkg::RD_B:   b <= rd_data;
          pnf_pkg::RD_B1:  begin tag <= a; a <= rd_data; end
          // hold the last second-level hash until its read slot
          pnf_pkg::RD_AA:  begin tag <= b; b <= rd_data; end
          pnf_pkg::RD_AB:  begin tag <= a; h_aa <= rd_data[2:0]; end
          pnf_pkg::RD_BA:  begin tag <= b; h_ab <= rd_data[2:0]; end
          pnf_pkg::RD_BB:  h_ba <= rd_data[2:0];
          default: begin end
        endcase
      end
      if (ctrl.lerp0) r0 <= lerp(g_aa, g_ba, u);
      if (ctrl.lerp0) r1 <= lerp(g_ab, g_bb, u);
      if (ctrl.lerp1) begin
        acc <= sum_next;
        oct <= oct + 1'b1;
        xs <= xs << 1;
        ys <= ys << 1;
      end
      if (ctrl.finish) begin
        if (acc > (F+7)'(19'sh3FFFF)) noise_value <= 19'sh3FFFF;
        else if (acc < -(F+7)'(20'sh40000)) noise_value <= -19'sh40000;
        else noise_value <= 19'(acc);
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/perlin_noise_2d_fbm_unit_test.sv @@
`timescale 1ns / 1ps
module perlin_noise_2d_fbm_unit_test;
  localparam int FRAC = 16;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic              command;
    logic [7:0]        entry_index;
    logic [7:0]        entry_value;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
  } request_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic command;
  logic [7:0] entry_index;
  logic [7:0] entry_value;
  logic signed [23:0] x_coord;
  logic signed [23:0] y_coord;
  logic cfg_we;
  logic [3:0] cfg_data;
  logic done;
  logic signed [18:0] noise_value;

  perlin_noise_2d_fbm_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .entry_index(entry_index), .entry_value(entry_value), .x_coord(x_coord),
    .y_coord(y_coord), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .noise_value(noise_value)
  );

  request_t pending[$];
  logic signed [18:0] expected_noise[$];
  logic [7:0] perm_model[256];
  logic [3:0] octaves_model;
  int errors;
  int idle_cycles;
  int gap;
  int drawn;
  bit drained;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint fade(longint f);
    longint s, poly, p1, t2, t3;
    s = 64'sd1 << FRAC;
    poly = 10 * s * s - 15 * f * s + 6 * f * f;
    p1 = poly >>> FRAC;
    t2 = (f * f) >>> FRAC;
    t3 = (t2 * f) >>> FRAC;
    return (t3 * p1) >>> FRAC;
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FRAC);
  endfunction

  function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
    case (h[2:0])
      3'd0: return dx + dy;
      3'd1: return -dx + dy;
      3'd2: return dx - dy;
      3'd3: return -dx - dy;
      3'd4: return dx;
      3'd5: return -dx;
      3'd6: return dy;
      default: return -dy;
    endcase
  endfunction

  function automatic longint octave_noise(longint xs, longint ys);
    logic [7:0] cx, cy, a, b, aa, ab, ba, bb;
    longint fx, fy, u, v, r0, r1;
    cx = xs[FRAC+7:FRAC];
    cy = ys[FRAC+7:FRAC];
    fx = xs & 64'hFFFF;
    fy = ys & 64'hFFFF;
    u = fade(fx);
    v = fade(fy);
    a = perm_model[cx] + cy;
    b = perm_model[8'(cx + 8'd1)] + cy;
    aa = perm_model[a];
    ab = perm_model[8'(a + 8'd1)];
    ba = perm_model[b];
    bb = perm_model[8'(b + 8'd1)];
    r0 = lerp(grad_dot(perm_model[aa], fx, fy),
              grad_dot(perm_model[ba], fx - 65536, fy), u);
    r1 = lerp(grad_dot(perm_model[ab], fx, fy - 65536),
              grad_dot(perm_model[bb], fx - 65536, fy - 65536), u);
    return lerp(r0, r1, v);
  endfunction

  function automatic logic signed [18:0] fbm_sum(logic signed [23:0] x,
                                                 logic signed [23:0] y);
    longint sum, xs, ys;
    int n;
    sum = 0;
    n = (octaves_model == 0) ? 1 : (octaves_model > 8) ? 8 : octaves_model;
    for (int i = 0; i < n; i++) begin
      xs = longint'(x) <<< i;
      ys = longint'(y) <<< i;
      sum += octave_noise(xs, ys) >>> i;
    end
    if (sum > 262143) sum = 262143;
    if (sum < -262144) sum = -262144;
    return sum[18:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic push_load(int idx, int val);
    request_t r;
    r = '0;
    r.command = CMD_LOAD;
    r.entry_index = 8'(idx);
    r.entry_value = 8'(val);
    pending.push_back(r);
  endtask

  task automatic push_eval(logic signed [23:0] x, logic signed [23:0] y);
    request_t r;
    r.command = CMD_EVAL;
    r.entry_index = 8'($urandom);
    r.entry_value = 8'($urandom);
    r.x_coord = x;
    r.y_coord = y;
    pending.push_back(r);
  endtask

  task automatic wait_drain();
    while (pending.size() != 0 || expected_noise.size() != 0 || busy) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic set_octaves(logic [3:0] n);
    cfg_data <= n;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    octaves_model = n;
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0)
        push_load($urandom, $urandom);
      else if ($urandom_range(0, 4) == 0)
        push_eval($urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000, 24'($urandom));
      else
        push_eval(24'($urandom), 24'($urandom));
    end
  endtask

  // driver: take the next request once the gap drawn for it has passed
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
      command <= CMD_LOAD;
      entry_index <= '0;
      entry_value <= '0;
      x_coord <= '0;
      y_coord <= '0;
    end else if (start && !busy) begin
      if (pending.size() != 0) begin
        if (pending[0].command == CMD_EVAL)
          expected_noise.push_back(fbm_sum(pending[0].x_coord, pending[0].y_coord));
        else
          perm_model[pending[0].entry_index] = pending[0].entry_value;
        void'(pending.pop_front());
      end
      drawn = $urandom_range(0, 4);
      if (drawn == 0 && pending.size() != 0) begin
        start <= 1'b1;
        command <= pending[0].command;
        entry_index <= pending[0].entry_index;
        entry_value <= pending[0].entry_value;
        x_coord <= pending[0].x_coord;
        y_coord <= pending[0].y_coord;
      end else begin
        start <= 1'b0;
      end
      gap <= drawn;
    end else if (!start && !busy && pending.size() != 0) begin
      if (gap == 0) begin
        start <= 1'b1;
        command <= pending[0].command;
        entry_index <= pending[0].entry_index;
        entry_value <= pending[0].entry_value;
        x_coord <= pending[0].x_coord;
        y_coord <= pending[0].y_coord;
      end else begin
        gap <= gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_noise.size() == 0)
        report_mismatch("result with no request outstanding");
      else if (noise_value !== expected_noise[0]) begin
        report_mismatch($sformatf("noise_value got %0d want %0d",
                                  noise_value, expected_noise[0]));
        void'(expected_noise.pop_front());
      end else
        void'(expected_noise.pop_front());
    end
  end

  // watchdog: count cycles in which nothing is accepted and no result appears
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || drained)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("perlin_noise_2d_fbm_unit verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [7:0] shuffle[256];
    errors = 0;
    drained = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 4'd4;
    octaves_model = 4'd4;
    for (int i = 0; i < 256; i++) perm_model[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // fill the table before any evaluation
    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      int j;
      logic [7:0] t;
      j = $urandom_range(0, i);
      t = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = t;
    end
    for (int i = 0; i < 256; i++) push_load(i, shuffle[i]);
    // directed: extremes, the origin and other fractional points at reset octave count
    push_eval(24'sh000000, 24'sh000000);
    push_eval(24'sh7FFFFF, 24'sh7FFFFF);
    push_eval(-24'sh800000, -24'sh800000);
    push_eval(24'sh7FFFFF, -24'sh800000);
    push_eval(24'sh00FFFF, 24'sh008000);
    push_eval(24'sh010000, -24'sh000001);
    push_eval(24'shFF0000, 24'sh00FFFF);
    push_load(8'hFF, 8'hFF);
    push_load(8'h00, 8'h00);
    push_eval(24'sh7F8000, 24'sh000100);
    wait_drain();
    set_octaves(4'd8);
    push_eval(24'sh7FFFFF, 24'sh7FFFFF);
    push_eval(24'sh123456, -24'sh654321);
    random_phase(400);
    wait_drain();
    set_octaves(4'd1);
    push_eval(-24'sh800000, 24'sh7FFFFF);
    random_phase(400);
    wait_drain();
    set_octaves(4'd0);
    random_phase(150);
    wait_drain();
    set_octaves(4'd15);
    random_phase(150);
    wait_drain();
    set_octaves(4'($urandom_range(2, 7)));
    random_phase(300);
    wait_drain();
    drained = 1'b1;
    if (errors == 0)
      $display("perlin_noise_2d_fbm_unit verification clean");
    else
      $display("perlin_noise_2d_fbm_unit verification failed");
    $finish;
  end
endmodule

@@ perlin_noise_2d_fbm_unit.f @@
rtl/pnf_pkg.sv
rtl/pnf_ctrl.sv
rtl/pnf_datapath.sv
rtl/perlin_noise_2d_fbm_unit.sv
tb/perlin_noise_2d_fbm_unit_test.sv
